/* rtl/core/gbs_pkg.sv */
// shared types and constants for the binomial gather schedule block
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int RANK_W    = 10;
    localparam int SIZE_W    = 11;
    localparam int COUNT_W   = 31;
    localparam int KIND_W    = 3;
    localparam int MAX_RANKS = 1024;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COPY      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RECV      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RECV_SPLIT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RECV_TEMP = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SEND      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SEND_TEMP = 3'd6;

    localparam logic CFG_GROUP_SIZE = 1'b0;
    localparam logic CFG_OWN_RANK   = 1'b1;

    typedef struct packed {
        logic [RANK_W-1:0]  root_rank;
        logic [COUNT_W-1:0] elem_count;
        logic               in_place;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] step_kind;
        logic [RANK_W-1:0] peer_rank;
        logic [RANK_W-1:0] first_offset;
        logic [SIZE_W-1:0] first_length;
        logic [RANK_W-1:0] second_offset;
        logic [SIZE_W-1:0] second_length;
        logic              last_step;
    } step_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [SIZE_W-1:0] group;
        logic [RANK_W-1:0] me;
        logic [RANK_W-1:0] root;
        logic [RANK_W-1:0] rel;
        logic              is_root;
        logic              zero;
        logic              in_place;
    } job_t;

endpackage

/* rtl/core/gbs_front.sv */
// front end: takes a request, reduces ranks modulo the group size, classifies it
`timescale 1ns / 1ps

module gbs_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  gbs_pkg::req_t              req,
    output logic                       busy,
    input  logic [gbs_pkg::SIZE_W-1:0] group_size,
    input  logic [gbs_pkg::RANK_W-1:0] own_rank,
    input  logic                       queue_full,
    output logic                       push,
    output gbs_pkg::job_t              job
);
    import gbs_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CALC = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam int CNT_W = $clog2(RANK_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RANK_W - 1);
    localparam logic [SIZE_W-1:0] G_MAX = SIZE_W'(MAX_RANKS);

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0] g_reg, g_next;
    logic [RANK_W-1:0] div_root_reg, div_root_next;
    logic [RANK_W-1:0] div_me_reg, div_me_next;
    logic [RANK_W-1:0] rem_root_reg, rem_root_next;
    logic [RANK_W-1:0] rem_me_reg, rem_me_next;
    logic              zero_reg, zero_next;
    logic              inplace_reg, inplace_next;

    logic [SIZE_W-1:0] g_clean;
    logic [SIZE_W-1:0] t_root, t_me;
    logic [SIZE_W-1:0] sum_rel;

    assign busy = (state_reg != F_IDLE);

    always_comb
    begin
        if (group_size == '0)
            g_clean = SIZE_W'(1);
        else if (group_size > G_MAX)
            g_clean = G_MAX;
        else
            g_clean = group_size;
    end

    // one restoring step per cycle for each remainder
    assign t_root = {rem_root_reg, div_root_reg[RANK_W-1]};
    assign t_me   = {rem_me_reg, div_me_reg[RANK_W-1]};

    assign sum_rel = {1'b0, rem_me_reg} + g_reg - {1'b0, rem_root_reg};

    always_comb
    begin
        job.group    = g_reg;
        job.me       = rem_me_reg;
        job.root     = rem_root_reg;
        job.rel      = (rem_me_reg >= rem_root_reg) ? rem_me_reg - rem_root_reg
                                                    : sum_rel[RANK_W-1:0];
        job.is_root  = (rem_me_reg == rem_root_reg);
        job.zero     = zero_reg;
        job.in_place = inplace_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        g_next        = g_reg;
        div_root_next = div_root_reg;
        div_me_next   = div_me_reg;
        rem_root_next = rem_root_reg;
        rem_me_next   = rem_me_reg;
        zero_next     = zero_reg;
        inplace_next  = inplace_reg;
        push          = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    state_next    = F_CALC;
                    cnt_next      = '0;
                    g_next        = g_clean;
                    div_root_next = req.root_rank;
                    div_me_next   = own_rank;
                    rem_root_next = '0;
                    rem_me_next   = '0;
                    zero_next     = (req.elem_count == '0);
                    inplace_next  = req.in_place;
                end
            end
            F_CALC:
            begin
                rem_root_next = (t_root >= g_reg) ? RANK_W'(t_root - g_reg)
                                                  : t_root[RANK_W-1:0];
                rem_me_next   = (t_me >= g_reg) ? RANK_W'(t_me - g_reg)
                                                : t_me[RANK_W-1:0];
                div_root_next = {div_root_reg[RANK_W-2:0], 1'b0};
                div_me_next   = {div_me_reg[RANK_W-2:0], 1'b0};
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        g_reg        <= g_next;
        div_root_reg <= div_root_next;
        div_me_reg   <= div_me_next;
        rem_root_reg <= rem_root_next;
        rem_me_reg   <= rem_me_next;
        zero_reg     <= zero_next;
        inplace_reg  <= inplace_next;
    end

endmodule

/* rtl/core/gbs_queue.sv */
// short job queue between the front end and the step generator
`timescale 1ns / 1ps

module gbs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbs_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output gbs_pkg::job_t pop_data
);
    import gbs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/core/gbs_back.sv */
// back end: walks the binomial rounds, emits a step for each round with a peer and takes a new job only when idle
`timescale 1ns / 1ps

module gbs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  gbs_pkg::job_t job,
    output logic          job_pop,
    output gbs_pkg::step_t step,
    output logic          step_valid
);
    import gbs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_NONE  = 2'd1;
    localparam logic [1:0] S_COPY  = 2'd2;
    localparam logic [1:0] S_ROUND = 2'd3;
    localparam int W = SIZE_W + 1;

    logic [1:0]        state_reg, state_next;
    job_t              job_reg, job_next;
    logic [SIZE_W-1:0] mask_reg, mask_next;
    logic [SIZE_W-1:0] temp_reg, temp_next;
    step_t             step_reg, step_next;
    logic              step_valid_reg, step_valid_next;

    logic [W-1:0] g12, m12, root12, me12, rel12, temp12;
    logic [W-1:0] src12, peer_sum, peer_w, dst_sum, dst_w;
    logic [W-1:0] blks_r, start_u, end_u, start_w, end_w, first_r, second_r;
    logic [W-1:0] blks_nr;
    logic         src_ok, hit, direct, root_last, single;

    assign g12    = {1'b0, job_reg.group};
    assign m12    = {1'b0, mask_reg};
    assign root12 = {2'b0, job_reg.root};
    assign me12   = {2'b0, job_reg.me};
    assign rel12  = {2'b0, job_reg.rel};
    assign temp12 = {1'b0, temp_reg};

    assign hit    = ((rel12 & m12) != '0);
    assign src12  = rel12 | m12;
    assign src_ok = (src12 < g12);

    assign peer_sum = src12 + root12;
    assign peer_w   = (peer_sum >= g12) ? peer_sum - g12 : peer_sum;
    assign dst_sum  = (rel12 ^ m12) + root12;
    assign dst_w    = (dst_sum >= g12) ? dst_sum - g12 : dst_sum;

    // root side: child subtree may run past the group end and wrap to slot 0
    assign blks_r   = ({m12[W-2:0], 1'b0} > g12) ? g12 - m12 : m12;
    assign start_u  = me12 + m12;
    assign end_u    = start_u + blks_r;
    assign start_w  = (start_u >= g12) ? start_u - g12 : start_u;
    assign end_w    = (end_u >= g12) ? end_u - g12 : end_u;
    assign direct   = (end_u == g12) || (start_w < end_w);
    assign first_r  = g12 - root12 - m12;
    assign second_r = blks_r - first_r;

    // non-root side: subtree clipped at the group end
    assign blks_nr  = ((src12 + m12) > g12) ? g12 - src12 : m12;

    assign root_last = ({m12[W-2:0], 1'b0} >= g12);
    assign single    = (job_reg.group == SIZE_W'(1));

    assign step       = step_reg;
    assign step_valid = step_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        mask_next       = mask_reg;
        temp_next       = temp_reg;
        step_next       = '0;
        step_valid_next = 1'b0;
        job_pop         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    job_next  = job;
                    mask_next = SIZE_W'(1);
                    temp_next = '0;
                    if (job.zero)
                        state_next = S_NONE;
                    else if (job.is_root && !job.in_place)
                        state_next = S_COPY;
                    else if (job.is_root && job.group == SIZE_W'(1))
                        state_next = S_NONE;
                    else
                        state_next = S_ROUND;
                end
            end
            S_NONE:
            begin
                step_valid_next     = 1'b1;
                step_next.step_kind = KIND_NONE;
                step_next.last_step = 1'b1;
                state_next          = S_IDLE;
            end
            S_COPY:
            begin
                step_valid_next        = 1'b1;
                step_next.step_kind    = KIND_COPY;
                step_next.peer_rank    = job_reg.me;
                step_next.first_offset = job_reg.me;
                step_next.first_length = SIZE_W'(1);
                step_next.last_step    = single;
                state_next             = single ? S_IDLE : S_ROUND;
            end
            S_ROUND:
            begin
                mask_next = {mask_reg[SIZE_W-2:0], 1'b0};
                if (hit)
                begin
                    // lowest set bit of the relative rank: send up and finish
                    step_valid_next        = 1'b1;
                    step_next.peer_rank    = dst_w[RANK_W-1:0];
                    step_next.first_length = SIZE_W'(1);
                    step_next.last_step    = 1'b1;
                    if (temp_reg == '0)
                        step_next.step_kind = KIND_SEND;
                    else
                    begin
                        step_next.step_kind     = KIND_SEND_TEMP;
                        step_next.second_length = temp_reg;
                    end
                    state_next = S_IDLE;
                end
                else if (src_ok)
                begin
                    step_valid_next     = 1'b1;
                    step_next.peer_rank = peer_w[RANK_W-1:0];
                    if (job_reg.is_root)
                    begin
                        step_next.last_step = root_last;
                        if (direct)
                        begin
                            step_next.step_kind    = KIND_RECV;
                            step_next.first_offset = start_w[RANK_W-1:0];
                            step_next.first_length = blks_r[SIZE_W-1:0];
                        end
                        else
                        begin
                            step_next.step_kind     = KIND_RECV_SPLIT;
                            step_next.first_offset  = RANK_W'(root12 + m12);
                            step_next.first_length  = first_r[SIZE_W-1:0];
                            step_next.second_length = second_r[SIZE_W-1:0];
                        end
                        if (root_last)
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        step_next.step_kind    = KIND_RECV_TEMP;
                        step_next.first_offset = RANK_W'(m12 - W'(1));
                        step_next.first_length = blks_nr[SIZE_W-1:0];
                        temp_next              = SIZE_W'(temp12 + blks_nr);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_valid_reg <= 1'b0;
            mask_reg       <= SIZE_W'(1);
            temp_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_valid_reg <= step_valid_next;
            mask_reg       <= mask_next;
            temp_reg       <= temp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        step_reg <= step_next;
    end

endmodule

/* rtl/core/binomial_gather_schedule_core.sv */
// top level: config registers, front end, job queue and step generator
// path: an accepted request passes the rank reduction, the queue and the step generator, whose step
//   output is registered; then one step per cycle, no step for a round with an absent child (1 to 11 steps)
// busy stays high through the bit-serial rank reduction and until the job is pushed into the queue;
//   the two-entry queue lets the next request start while steps still go out
// steps cannot be held off; reset clears control state, group_size to 1, own_rank to 0
`timescale 1ns / 1ps

module binomial_gather_schedule_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  gbs_pkg::req_t              req,
    output logic                       busy,
    output gbs_pkg::step_t             step,
    output logic                       step_valid,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [gbs_pkg::SIZE_W-1:0] cfg_data
);
    import gbs_pkg::*;

    logic [SIZE_W-1:0] group_size_reg, group_size_next;
    logic [RANK_W-1:0] own_rank_reg, own_rank_next;

    logic queue_full, push, job_valid, job_pop;
    job_t push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        group_size_next = group_size_reg;
        own_rank_next   = own_rank_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GROUP_SIZE: group_size_next = cfg_data;
                CFG_OWN_RANK:   own_rank_next   = cfg_data[RANK_W-1:0];
                default:        group_size_next = group_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= SIZE_W'(1);
            own_rank_reg   <= '0;
        end
        else
        begin
            group_size_reg <= group_size_next;
            own_rank_reg   <= own_rank_next;
        end
    end

    gbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .busy       (busy),
        .group_size (group_size_reg),
        .own_rank   (own_rank_reg),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    gbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (job_pop),
        .valid     (job_valid),
        .pop_data  (pop_job)
    );

    gbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (pop_job),
        .job_pop    (job_pop),
        .step       (step),
        .step_valid (step_valid)
    );

endmodule

/* tb/sv/binomial_gather_schedule_core_tb.sv */
// testbench for binomial_gather_schedule_core: directed and random gather requests
`timescale 1ns / 1ps

module binomial_gather_schedule_core_tb;

    import gbs_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 35;
    localparam int RANDOM_PHASES = 7;

    // predicts the step run of each request and matches it against the block
    class schedule_scoreboard;
        logic [SIZE_W-1:0] group_size;
        logic [RANK_W-1:0] own_rank;
        step_t             expected_steps[$];
        int                mismatches;
        int                requests;
        int                steps_checked;
        int                reg_writes;
        int                kind_seen[8];

        function new();
            group_size = SIZE_W'(1);
            own_rank = '0;
            mismatches = 0;
            requests = 0;
            steps_checked = 0;
            reg_writes = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void set_register(logic idx, logic [SIZE_W-1:0] data);
            reg_writes++;
            if (idx == CFG_GROUP_SIZE)
                group_size = data;
            else
                own_rank = data[RANK_W-1:0];
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        function step_t make_step(logic [KIND_W-1:0] kind, int peer, int fo, int fl,
                                  int so, int sl);
            step_t s;
            s.step_kind = kind;
            s.peer_rank = peer[RANK_W-1:0];
            s.first_offset = fo[RANK_W-1:0];
            s.first_length = fl[SIZE_W-1:0];
            s.second_offset = so[RANK_W-1:0];
            s.second_length = sl[SIZE_W-1:0];
            s.last_step = 1'b0;
            return s;
        endfunction

        function void note_request(req_t r);
            step_t run[$];
            step_t tail;
            int g, me, root, rel, m, src, peer, blks, st, stop, first_blks, dst, temp;
            bit is_root;
            requests++;
            g = group_size;
            if (g == 0)
                g = 1;
            if (g > MAX_RANKS)
                g = MAX_RANKS;
            me = own_rank % g;
            root = r.root_rank % g;
            temp = 0;
            if (r.elem_count != 0) begin
                rel = (me >= root) ? me - root : me + g - root;
                is_root = (me == root);
                if (is_root && !r.in_place)
                    run.push_back(make_step(KIND_COPY, me, me, 1, 0, 0));
                for (m = 1; m < g; m = m << 1) begin
                    if ((m & rel) == 0) begin
                        src = rel | m;
                        if (src < g) begin
                            peer = src + root;
                            if (peer >= g)
                                peer -= g;
                            if (is_root) begin
                                blks = m;
                                st = me + m;
                                if (2 * blks > g)
                                    blks = g - blks;
                                stop = st + blks;
                                if (st >= g)
                                    st -= g;
                                if (stop >= g)
                                    stop -= g;
                                if (me + m + blks == g || st < stop)
                                    run.push_back(make_step(KIND_RECV, peer, st, blks, 0, 0));
                                else begin
                                    // root's block range wraps past the last rank
                                    first_blks = g - root - m;
                                    run.push_back(make_step(KIND_RECV_SPLIT, peer, root + m,
                                                            first_blks, 0, blks - first_blks));
                                end
                            end
                            else begin
                                blks = m;
                                if (src + m > g)
                                    blks -= src + m - g;
                                run.push_back(make_step(KIND_RECV_TEMP, peer, m - 1, blks, 0, 0));
                                temp += blks;
                            end
                        end
                    end
                    else begin
                        dst = (rel ^ m) + root;
                        if (dst >= g)
                            dst -= g;
                        if (temp == 0)
                            run.push_back(make_step(KIND_SEND, dst, 0, 1, 0, 0));
                        else
                            run.push_back(make_step(KIND_SEND_TEMP, dst, 0, 1, 0, temp));
                        break;
                    end
                end
            end
            if (run.size() == 0)
                run.push_back(make_step(KIND_NONE, 0, 0, 0, 0, 0));
            tail = run.pop_back();
            tail.last_step = 1'b1;
            run.push_back(tail);
            foreach (run[i]) expected_steps.push_back(run[i]);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, int got, int want);
            if (got != want)
                report($sformatf("step %0d %s got %0d expected %0d",
                                 steps_checked, name, got, want));
        endtask

        task check_step(step_t got);
            step_t want;
            kind_seen[got.step_kind]++;
            if (expected_steps.size() == 0) begin
                report($sformatf("step kind %0d with no request pending", got.step_kind));
                return;
            end
            want = expected_steps.pop_front();
            check_field("step_kind", got.step_kind, want.step_kind);
            check_field("peer_rank", got.peer_rank, want.peer_rank);
            check_field("first_offset", got.first_offset, want.first_offset);
            check_field("first_length", got.first_length, want.first_length);
            check_field("second_offset", got.second_offset, want.second_offset);
            check_field("second_length", got.second_length, want.second_length);
            check_field("last_step", got.last_step, want.last_step);
            steps_checked++;
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    req_t              req;
    logic              busy;
    step_t             step;
    logic              step_valid;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    schedule_scoreboard sb;
    int                 stall_cycles;
    bit                 calm;
    int                 cur_group;
    int                 cur_own;

    binomial_gather_schedule_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .busy       (busy),
        .step       (step),
        .step_valid (step_valid),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sample every handshake at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || step_valid || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (start && !busy)
                sb.note_request(req);
            if (step_valid)
                sb.check_step(step);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
        end
    end

    initial
    begin
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function int idle_gap();
        if (calm || $urandom_range(0, 99) >= 7)
            return 0;
        return $urandom_range(1, 5);
    endfunction

    function req_t make_req(int root, logic [COUNT_W-1:0] count, logic ip);
        req_t r;
        r.root_rank = root[RANK_W-1:0];
        r.elem_count = count;
        r.in_place = ip;
        return r;
    endfunction

    task send_request(input req_t r);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task write_reg(input logic idx, input logic [SIZE_W-1:0] data);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // let every pending step come out before touching the registers
    task drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task configure(input int g, input int own);
        drain();
        write_reg(CFG_GROUP_SIZE, g[SIZE_W-1:0]);
        write_reg(CFG_OWN_RANK, own[SIZE_W-1:0]);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_group = (g == 0) ? 1 : ((g > MAX_RANKS) ? MAX_RANKS : g);
        cur_own = own[RANK_W-1:0] % cur_group;
    endtask

    function int pick_group();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(2, 16);
        if (r < 70)
            return $urandom_range(17, 64);
        if (r < 80)
            return $urandom_range(65, 1024);
        if (r < 85)
            return MAX_RANKS;
        if (r < 90)
            return $urandom_range(0, 1);
        return $urandom_range(1025, 2047);
    endfunction

    function int pick_own(int g);
        int r, geff;
        geff = (g == 0) ? 1 : ((g > MAX_RANKS) ? MAX_RANKS : g);
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, geff - 1);
        if (r < 85)
            return ($urandom_range(0, 1) != 0) ? geff - 1 : 0;
        return $urandom_range(0, 2047);
    endfunction

    function req_t random_req();
        int r, root;
        logic [COUNT_W-1:0] count;
        r = $urandom_range(0, 99);
        if (r < 35)
            root = cur_own;
        else if (r < 85)
            root = $urandom_range(0, cur_group - 1);
        else
            root = $urandom_range(0, 1023);
        r = $urandom_range(0, 99);
        if (r < 10)
            count = '0;
        else if (r < 30)
            count = COUNT_W'($urandom_range(1, 100));
        else
            count = COUNT_W'($urandom());
        return make_req(root, count, 1'($urandom_range(0, 1)));
    endfunction

    initial
    begin
        int p, i;
        sb = new();
        calm = 1'b0;
        cur_group = 1;
        cur_own = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GROUP_SIZE;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: group of one
        send_request(make_req(0, 31'd0, 1'b0));
        send_request(make_req(0, 31'h7FFF_FFFF, 1'b1));
        send_request(make_req(1023, 31'd1, 1'b0));

        configure(8, 0);
        send_request(make_req(0, 31'd5, 1'b0));
        send_request(make_req(0, 31'd5, 1'b1));
        send_request(make_req(3, 31'd77, 1'b0));

        // root at rank 5 of 8 wraps its second receive
        configure(8, 5);
        send_request(make_req(5, 31'd1, 1'b0));
        send_request(make_req(5, 31'd0, 1'b0));
        send_request(make_req(0, 31'd123, 1'b1));
        send_request(make_req(4, 31'd9, 1'b1));

        configure(7, 6);
        send_request(make_req(0, 31'd42, 1'b0));
        send_request(make_req(6, 31'd3, 1'b1));
        send_request(make_req(1023, 31'd3, 1'b0));

        configure(1024, 1023);
        send_request(make_req(1023, 31'h7FFF_FFFF, 1'b0));
        send_request(make_req(0, 31'd2, 1'b1));
        send_request(make_req(512, 31'd100, 1'b0));

        // group size zero behaves as one
        configure(0, 0);
        send_request(make_req(0, 31'd8, 1'b0));
        send_request(make_req(1023, 31'd8, 1'b1));

        // oversized group saturates
        configure(2047, 512);
        send_request(make_req(513, 31'd55, 1'b1));
        send_request(make_req(0, 31'd1, 1'b0));

        // own rank above group size wraps
        configure(1000, 1023);
        send_request(make_req(999, 31'd3, 1'b0));
        send_request(make_req(23, 31'h4000_0000, 1'b0));

        for (p = 0; p < RANDOM_PHASES; p++) begin
            calm = 1'b0;
            i = pick_group();
            configure(i, pick_own(i));
            calm = (p == 3);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_request(random_req());
        end
        calm = 1'b0;

        drain();
        $display("ran %0d requests through %0d register writes, %0d steps checked",
                 sb.requests, sb.reg_writes, sb.steps_checked);
        $display({"steps by kind: none %0d copy %0d recv %0d split %0d temp %0d",
                  " send %0d send+temp %0d"},
                 sb.kind_seen[KIND_NONE], sb.kind_seen[KIND_COPY], sb.kind_seen[KIND_RECV],
                 sb.kind_seen[KIND_RECV_SPLIT], sb.kind_seen[KIND_RECV_TEMP],
                 sb.kind_seen[KIND_SEND], sb.kind_seen[KIND_SEND_TEMP]);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
